// ===== hw/rtl/b62enc_pkg.sv =====
package b62enc_pkg;

   localparam int VALUE_W       = 64;
   localparam int CHAR_W        = 7;
   localparam int RADIX         = 62;
   localparam int DIGIT_W       = 6;
   localparam int DIGITS        = 11;
   localparam int IDX_W         = $clog2(DIGITS);
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(STEPS);

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [DIGITS-1:0] digit_vec_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic find;
      logic emit_next;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic step_done;
      logic last_digit;
   } dp_sts_type;

endpackage

// ===== hw/rtl/b62enc_req_if.sv =====
interface b62enc_req_if;
   import b62enc_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] id_value;

   modport source (output valid, output id_value, input ready);
   modport sink (input valid, input id_value, output ready);
endinterface

// ===== hw/rtl/b62enc_rsp_if.sv =====
interface b62enc_rsp_if;
   import b62enc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink (input valid, input char_code, input is_last, output ready);
endinterface

// ===== hw/rtl/b62enc_ctrl.sv =====
module b62enc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output b62enc_pkg::dp_cmd_type cmd,
   input  b62enc_pkg::dp_sts_type sts
);
   import b62enc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_FIND = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (sts.step_done) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/b62enc_dp.sv =====
module b62enc_dp (
   input  logic                         clock,
   input  logic [b62enc_pkg::VALUE_W-1:0] id_value,
   input  b62enc_pkg::dp_cmd_type       cmd,
   output b62enc_pkg::dp_sts_type       sts,
   output logic [b62enc_pkg::CHAR_W-1:0] char_code,
   output logic                         is_last
);
   import b62enc_pkg::*;

   localparam int HALF_RADIX = RADIX / 2;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_OFS = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_OFS = 7'd55;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_OFS = 7'd61;

   logic [VALUE_W-1:0]    value_ff, value_in;
   digit_vec_type         digits_ff, digits_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   // double every digit and shift one bit in; a digit at or above half
   // the radix wraps and carries, so carries never ripple
   function automatic digit_vec_type shift_in(digit_vec_type d, logic b);
      digit_vec_type    r;
      logic             c;
      logic [DIGIT_W:0] t;
      for (int i = 0; i < DIGITS; i++) begin
         c = (i == 0) ? b : (d[i-1] >= DIGIT_W'(HALF_RADIX));
         t = {d[i], c};
         if (d[i] >= DIGIT_W'(HALF_RADIX)) begin
            t = t - (DIGIT_W+1)'(RADIX);
         end
         r[i] = t[DIGIT_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(digit_type d);
      logic [CHAR_W-1:0] w;
      w = CHAR_W'(d);
      if (d < 6'd10) begin
         return w + CHAR_DIGIT_OFS;
      end else if (d < 6'd36) begin
         return w + CHAR_UPPER_OFS;
      end else if (d < DIGIT_W'(RADIX)) begin
         return w + CHAR_LOWER_OFS;
      end
      return CHAR_DIGIT_OFS;
   endfunction

   always_comb begin
      value_in  = value_ff;
      digits_in = digits_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      if (cmd.load) begin
         value_in  = id_value;
         digits_in = '0;
         cnt_in    = '0;
      end else if (cmd.step) begin
         for (int j = 0; j < BITS_PER_STEP; j++) begin
            digits_in = shift_in(digits_in, value_ff[VALUE_W-1-j]);
         end
         value_in = value_ff << BITS_PER_STEP;
         cnt_in   = cnt_ff + 1'b1;
      end else if (cmd.find) begin
         idx_in = '0;
         for (int i = 1; i < DIGITS; i++) begin
            if (digits_ff[i] != '0) begin
               idx_in = IDX_W'(i);
            end
         end
      end else if (cmd.emit_next) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      digits_ff <= digits_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
   end

   assign sts.step_done  = (cnt_ff == STEP_CNT_W'(STEPS - 1));
   assign sts.last_digit = (idx_ff == '0);
   assign char_code      = digit_to_char(digits_ff[idx_ff]);
   assign is_last        = sts.last_digit;

endmodule

// ===== hw/rtl/base62_encoder_unit.sv =====
// base-62 encoder
//
// req_chan: one beat carries a 64-bit unsigned id_value; taken when valid
// and ready are both high. ready is high only while the unit is idle.
// rsp_chan: one beat per character, most significant digit first, ascii
// 0-9, A-Z, a-z; is_last marks the final character. zero gives one '0'.
//
// the value is converted to base 62 four input bits per cycle by
// doubling an eleven-digit register in a conversion loop; a find step
// then locates the leading digit. characters leave one per cycle while
// the receiver does not stall, and after the last one the unit returns
// to idle before the next request is taken.
//
// a stalled receiver holds the current character and is_last steady; the
// unit waits and takes no request until the last beat is gone.
// reset (synchronous) returns the controller to idle; no data is kept.
module base62_encoder_unit (
   input logic   clock,
   input logic   reset,
   b62enc_req_if.sink   req_chan,
   b62enc_rsp_if.source rsp_chan
);
   import b62enc_pkg::*;

   // command and status between controller and datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: idle, convert, find leading digit, emit
   b62enc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // digit register, shift register of input bits and output select
   b62enc_dp u_dp (
      .clock     (clock),
      .id_value  (req_chan.id_value),
      .cmd       (cmd),
      .sts       (sts),
      .char_code (rsp_chan.char_code),
      .is_last   (rsp_chan.is_last)
   );

endmodule

// ===== hw/rtl/b62enc_checker.sv =====
module b62enc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [b62enc_pkg::CHAR_W-1:0] char_code,
   input logic                          is_last
);

   // one item at a time: no request taken while characters are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a character is pending");

   // after a request beat the unit is busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after a request beat");

   // only alphabet characters leave
   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((char_code >= 7'd48 && char_code <= 7'd57) ||
                     (char_code >= 7'd65 && char_code <= 7'd90) ||
                     (char_code >= 7'd97 && char_code <= 7'd122)))
      else $error("character outside the base-62 alphabet");

   // the run ends after its last beat
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && is_last) |=> !rsp_valid)
      else $error("output still valid after the last beat");

   // stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(char_code) && $stable(is_last)))
      else $error("stalled beat changed");

endmodule

bind base62_encoder_unit b62enc_checker u_b62enc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .char_code (rsp_chan.char_code),
   .is_last   (rsp_chan.is_last)
);

// ===== tb/base62_encoder_unit_tb.sv =====
module base62_encoder_unit_tb;
   import b62enc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one character beat as the unit should send it
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              is_last;
   } b62_char_type;

   logic clock;
   logic reset;

   b62enc_req_if req_bus ();
   b62enc_rsp_if rsp_bus ();

   base62_encoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // numbers still to send, and characters the unit still owes us
   logic [VALUE_W-1:0] id_backlog[$];
   b62_char_type       encoded_chars[$];

   int error_count;
   int ids_total;
   int ids_taken;

   // sender burst / gap bookkeeping
   int gap_left;
   int burst_left;

   // receiver stall pattern, reloaded each time the phase wraps to zero
   logic [15:0] stall_mask;
   int          stall_phase;

   // ------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [VALUE_W-1:0] pow62(input int k);
      logic [VALUE_W-1:0] p;
      p = 1;
      for (int i = 0; i < k; i++) p = p * RADIX;
      return p;
   endfunction

   // splits the number into base-62 digits, then queues the ascii
   // characters most significant first, marking the final one
   task automatic encode_base62(input logic [VALUE_W-1:0] id_value);
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] digit_buf[DIGITS];
      int                 n_digits;
      logic [DIGIT_W-1:0] d;
      b62_char_type       c;
      rest     = id_value;
      n_digits = 0;
      // do-while shape: zero still yields one digit
      do begin
         if (n_digits < DIGITS) begin
            digit_buf[n_digits] = DIGIT_W'(rest % RADIX);
            n_digits++;
         end
         rest = rest / RADIX;
      end while (rest != 0);
      for (int k = n_digits - 1; k >= 0; k--) begin
         d = digit_buf[k];
         if (d < 10)      c.char_code = CHAR_W'(7'd48 + d);         // '0'..'9'
         else if (d < 36) c.char_code = CHAR_W'(7'd65 + d - 7'd10); // 'A'..'Z'
         else             c.char_code = CHAR_W'(7'd97 + d - 7'd36); // 'a'..'z'
         c.is_last = (k == 0);
         encoded_chars.push_back(c);
      end
   endtask

   // ------------------------------------------------------------------
   // request driver: bursts of beats separated by random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left   = 0;
         burst_left = 0;
      end else begin
         // a beat was taken at this edge: predict its characters now
         if (req_bus.valid && req_bus.ready) begin
            encode_base62(req_bus.id_value);
            ids_taken++;
         end
         // valid stays up until the beat is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || id_backlog.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid    <= 1'b0;
               // junk payload while idle, the unit must ignore it
               req_bus.id_value <= {$urandom, $urandom};
            end else begin
               req_bus.valid    <= 1'b1;
               req_bus.id_value <= id_backlog.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  // about a third of the bursts run back to back
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor and receiver stall pattern
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mask  = '0;
         stall_phase = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (encoded_chars.size() == 0) begin
               report_mismatch($sformatf("character beat 0x%02h with nothing pending",
                                         rsp_bus.char_code));
            end else begin
               b62_char_type want;
               want = encoded_chars.pop_front();
               if (rsp_bus.char_code !== want.char_code)
                  report_mismatch($sformatf("char_code got 0x%02h want 0x%02h",
                                            rsp_bus.char_code, want.char_code));
               if (rsp_bus.is_last !== want.is_last)
                  report_mismatch($sformatf("is_last got %b want %b (char 0x%02h)",
                                            rsp_bus.is_last, want.is_last,
                                            want.char_code));
            end
         end
         // pick a new 16-bit ready pattern each time the phase wraps to zero
         if (stall_phase == 0) begin
            case ($urandom_range(0, 4))
               0, 1: stall_mask = '1;                 // never stall
               2: stall_mask = 16'($urandom);       // random choppy stalls
               3: stall_mask = 16'($urandom) | 16'($urandom);  // light stalls
               default: stall_mask = 16'h8000;      // one long stall
            endcase
         end
         rsp_bus.ready <= stall_mask[stall_phase];
         stall_phase = (stall_phase + 1) % 16;
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      logic [VALUE_W-1:0] v;
      int                 k;
      error_count = 0;
      ids_taken   = 0;
      req_bus.valid    = 1'b0;
      req_bus.id_value = '0;
      rsp_bus.ready    = 1'b0;

      // directed: zero, digit class edges, digit count edges, full range
      id_backlog.push_back(64'd0);
      id_backlog.push_back(64'd1);
      id_backlog.push_back(64'd9);
      id_backlog.push_back(64'd10);
      id_backlog.push_back(64'd35);
      id_backlog.push_back(64'd36);
      id_backlog.push_back(64'd61);
      id_backlog.push_back(64'd62);
      id_backlog.push_back(64'd63);
      id_backlog.push_back(pow62(2) - 1);
      id_backlog.push_back(pow62(2));
      id_backlog.push_back(pow62(10) - 1);   // ten 'z' characters
      id_backlog.push_back(pow62(10));       // first eleven-character value
      id_backlog.push_back(64'h7FFF_FFFF_FFFF_FFFF);
      id_backlog.push_back(64'h8000_0000_0000_0000);
      id_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFE);
      id_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      id_backlog.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      id_backlog.push_back(64'h5555_5555_5555_5555);
      id_backlog.push_back(64'h0123_4567_89AB_CDEF);

      // random part, mixed so every run length shows up often
      for (int i = 0; i < 300; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: v = {$urandom, $urandom};
            4, 5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            6: v = 64'($urandom_range(0, 61));
            7: begin
               k = $urandom_range(1, 10);
               v = pow62(k) + 64'($urandom_range(0, 2)) - 64'd1;
            end
            8: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
            default: v = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
         endcase
         id_backlog.push_back(v);
      end
      ids_total = id_backlog.size();

      // every request taken and every character back
      while (ids_taken < ids_total || encoded_chars.size() != 0) @(negedge clock);
      // let any stray beat show up
      repeat (50) @(negedge clock);

      if (encoded_chars.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", encoded_chars.size()));

      if (error_count == 0) begin
         $display("base62_encoder_unit_tb: done, clean");
      end else begin
         $display("base62_encoder_unit_tb: done, errors");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d of %0d requests taken, %0d characters pending",
               $time, ids_taken, ids_total, encoded_chars.size());
      $display("base62_encoder_unit_tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/b62enc_pkg.sv
hw/rtl/b62enc_req_if.sv
hw/rtl/b62enc_rsp_if.sv
hw/rtl/b62enc_ctrl.sv
hw/rtl/b62enc_dp.sv
hw/rtl/base62_encoder_unit.sv
hw/rtl/b62enc_checker.sv
tb/base62_encoder_unit_tb.sv
